### src/tprl_pkg.sv
package tprl_pkg;

  localparam int ADC_BITS   = 10;
  localparam int PULSE_BITS = 12;
  localparam int WATT_BITS  = 14;
  localparam int STEP_BITS  = 10;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 14;

  // Power scale, Q0.24: about 0.0102279 W per count^2
  localparam int                K_BITS   = 18;
  localparam logic [K_BITS-1:0] PWR_K    = 18'd171596;
  localparam int                PWR_FRAC = 24;

  localparam int PWR_PROD_BITS = 2 * ADC_BITS + K_BITS;
  localparam int LIMIT_BITS    = WATT_BITS + PWR_FRAC;
  localparam int ALU_W         = (PWR_PROD_BITS > LIMIT_BITS) ? PWR_PROD_BITS : LIMIT_BITS;
  localparam int MPLR_BITS     = (ADC_BITS > K_BITS) ? ADC_BITS : K_BITS;
  localparam int MAX_STEPS     = (MPLR_BITS > PULSE_BITS) ? MPLR_BITS : PULSE_BITS;
  localparam int CNT_BITS      = $clog2(MAX_STEPS);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_THROTTLE_LOW  = 3'd0,
    CFG_THROTTLE_HIGH = 3'd1,
    CFG_PULSE_LOW     = 3'd2,
    CFG_PULSE_HIGH    = 3'd3,
    CFG_WATT_LIMIT    = 3'd4,
    CFG_RAMP_UP_STEP  = 3'd5,
    CFG_RAMP_DOWN     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [ADC_BITS-1:0]   throttle_low;
    logic [ADC_BITS-1:0]   throttle_high;
    logic [PULSE_BITS-1:0] pulse_low;
    logic [PULSE_BITS-1:0] pulse_high;
    logic [WATT_BITS-1:0]  watt_limit;
    logic [STEP_BITS-1:0]  ramp_up_step;
    logic [STEP_BITS-1:0]  ramp_down_step;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    throttle_low:   ADC_BITS'(0),
    throttle_high:  ADC_BITS'(1023),
    pulse_low:      PULSE_BITS'(1000),
    pulse_high:     PULSE_BITS'(2000),
    watt_limit:     WATT_BITS'(16383),
    ramp_up_step:   STEP_BITS'(1),
    ramp_down_step: STEP_BITS'(1)
  };

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

endpackage

### src/tprl_if.sv
interface tprl_in_if;
  import tprl_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] throttle_sample;
  logic [ADC_BITS-1:0] voltage_sample;
  logic [ADC_BITS-1:0] current_sample;

  modport source (output valid, throttle_sample, voltage_sample, current_sample, input ready);
  modport sink   (input valid, throttle_sample, voltage_sample, current_sample, output ready);
endinterface

interface tprl_out_if;
  import tprl_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PULSE_BITS-1:0] drive_pulse;

  modport source (output valid, drive_pulse, input ready);
  modport sink   (input valid, drive_pulse, output ready);
endinterface

### src/tprl_alu.sv
module tprl_alu (
  input  tprl_pkg::alu_req_t         req_i,
  output logic [tprl_pkg::ALU_W:0]   res_o
);
  import tprl_pkg::*;

  logic [ALU_W:0] b_ext;

  // Subtract: top bit of the result is the borrow (a < b)
  assign b_ext = {1'b0, req_i.b} ^ {(ALU_W + 1){req_i.sub}};
  assign res_o = {1'b0, req_i.a} + b_ext + (ALU_W + 1)'(req_i.sub);

endmodule

### src/tprl_core.sv
module tprl_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tprl_pkg::cfg_t                  cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [tprl_pkg::ADC_BITS-1:0]   throttle_i,
  input  logic [tprl_pkg::ADC_BITS-1:0]   voltage_i,
  input  logic [tprl_pkg::ADC_BITS-1:0]   current_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tprl_pkg::PULSE_BITS-1:0] drive_pulse_o
);
  import tprl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MAP, S_MUL_A, S_DIV, S_MUL_VC, S_MUL_K, S_CMP, S_RAMP
  } state_e;

  state_e                state_q, state_d;
  logic [ADC_BITS-1:0]   t_q, t_d, v_q, v_d, c_q, c_d;
  logic [ALU_W-1:0]      acc_q, acc_d, mcand_q, mcand_d;
  logic [MPLR_BITS-1:0]  mplr_q, mplr_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [PULSE_BITS-1:0] quo_q, quo_d, req_q, req_d, power_q, power_d;
  logic [PULSE_BITS-1:0] out_data_q, out_data_d;
  logic                  neg_q, neg_d, over_q, over_d, out_valid_q, out_valid_d;

  alu_req_t              alu_req;
  logic [ALU_W:0]        alu_res;

  logic [ALU_W-1:0]      acc_step;
  logic [PULSE_BITS-1:0] quo_next;
  logic                  start_vc;
  logic [PULSE_BITS:0]   up_sum, floor_sum;
  logic [PULSE_BITS-1:0] down_val, ramp_val;
  logic                  go_down, go_up;

  tprl_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  always_comb begin
    alu_req.a   = acc_q;
    alu_req.b   = mcand_q;
    alu_req.sub = 1'b0;
    unique case (state_q)
      S_DIV: alu_req.sub = 1'b1;
      S_CMP: begin
        alu_req.b   = ALU_W'(cfg_i.watt_limit) << PWR_FRAC;
        alu_req.sub = 1'b1;
      end
      default: ;
    endcase
  end

  // Multiply step result and division quotient bit
  assign acc_step = mplr_q[0] ? alu_res[ALU_W-1:0] : acc_q;
  assign quo_next = {quo_q[PULSE_BITS-2:0], ~alu_res[ALU_W]};

  // Ramp decision on narrow values
  assign up_sum    = {1'b0, power_q} + (PULSE_BITS + 1)'(cfg_i.ramp_up_step);
  assign floor_sum = {1'b0, cfg_i.pulse_low} + (PULSE_BITS + 1)'(cfg_i.ramp_down_step);
  assign down_val  = ({1'b0, power_q} < floor_sum) ? cfg_i.pulse_low
                   : power_q - PULSE_BITS'(cfg_i.ramp_down_step);
  assign go_down   = over_q || (up_sum > {1'b0, req_q});
  assign go_up     = up_sum < {1'b0, req_q};
  assign ramp_val  = go_down ? down_val : (go_up ? up_sum[PULSE_BITS-1:0] : power_q);

  always_comb begin
    state_d     = state_q;
    t_d         = t_q;
    v_d         = v_q;
    c_d         = c_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplr_d      = mplr_q;
    cnt_d       = cnt_q;
    quo_d       = quo_q;
    req_d       = req_q;
    power_d     = power_q;
    neg_d       = neg_q;
    over_d      = over_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;
    start_vc    = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          t_d     = throttle_i;
          v_d     = voltage_i;
          c_d     = current_i;
          state_d = S_MAP;
        end
      end
      S_MAP: begin
        if (t_q < cfg_i.throttle_low) begin
          req_d    = cfg_i.pulse_low;
          start_vc = 1'b1;
        end else if (t_q > cfg_i.throttle_high) begin
          req_d    = cfg_i.pulse_high;
          start_vc = 1'b1;
        end else if (cfg_i.throttle_high == cfg_i.throttle_low) begin
          req_d    = cfg_i.pulse_low;
          start_vc = 1'b1;
        end else begin
          // |pulse span| * (throttle - low), sign applied after the divide
          neg_d   = cfg_i.pulse_high < cfg_i.pulse_low;
          mcand_d = (cfg_i.pulse_high < cfg_i.pulse_low)
                  ? ALU_W'(cfg_i.pulse_low - cfg_i.pulse_high)
                  : ALU_W'(cfg_i.pulse_high - cfg_i.pulse_low);
          mplr_d  = MPLR_BITS'(t_q - cfg_i.throttle_low);
          acc_d   = '0;
          cnt_d   = CNT_BITS'(ADC_BITS - 1);
          state_d = S_MUL_A;
        end
      end
      S_MUL_A: begin
        acc_d   = acc_step;
        mcand_d = mcand_q << 1;
        mplr_d  = mplr_q >> 1;
        cnt_d   = cnt_q - CNT_BITS'(1);
        if (cnt_q == '0) begin
          mcand_d = ALU_W'(cfg_i.throttle_high - cfg_i.throttle_low) << (PULSE_BITS - 1);
          quo_d   = '0;
          cnt_d   = CNT_BITS'(PULSE_BITS - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        // restoring divide, quotient fits the pulse width by construction
        if (!alu_res[ALU_W]) begin
          acc_d = alu_res[ALU_W-1:0];
        end
        quo_d   = quo_next;
        mcand_d = mcand_q >> 1;
        cnt_d   = cnt_q - CNT_BITS'(1);
        if (cnt_q == '0) begin
          req_d    = neg_q ? cfg_i.pulse_low - quo_next : cfg_i.pulse_low + quo_next;
          start_vc = 1'b1;
        end
      end
      S_MUL_VC: begin
        acc_d   = acc_step;
        mcand_d = mcand_q << 1;
        mplr_d  = mplr_q >> 1;
        cnt_d   = cnt_q - CNT_BITS'(1);
        if (cnt_q == '0) begin
          mcand_d = acc_step;
          acc_d   = '0;
          mplr_d  = MPLR_BITS'(PWR_K);
          cnt_d   = CNT_BITS'(K_BITS - 1);
          state_d = S_MUL_K;
        end
      end
      S_MUL_K: begin
        acc_d   = acc_step;
        mcand_d = mcand_q << 1;
        mplr_d  = mplr_q >> 1;
        cnt_d   = cnt_q - CNT_BITS'(1);
        if (cnt_q == '0) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        over_d  = ~alu_res[ALU_W];
        state_d = S_RAMP;
      end
      S_RAMP: begin
        // wait here while the previous result is still unclaimed
        if (!out_valid_q || out_ready_i) begin
          power_d     = ramp_val;
          out_data_d  = ramp_val;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (start_vc) begin
      mcand_d = ALU_W'(v_q);
      mplr_d  = MPLR_BITS'(c_q);
      acc_d   = '0;
      cnt_d   = CNT_BITS'(ADC_BITS - 1);
      state_d = S_MUL_VC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      power_q     <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      power_q     <= power_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q        <= t_d;
    v_q        <= v_d;
    c_q        <= c_d;
    acc_q      <= acc_d;
    mcand_q    <= mcand_d;
    mplr_q     <= mplr_d;
    quo_q      <= quo_d;
    req_q      <= req_d;
    neg_q      <= neg_d;
    over_q     <= over_d;
    out_data_q <= out_data_d;
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign drive_pulse_o = out_data_q;

endmodule

### src/throttle_power_ramp_limiter.sv
// Throttle power ramp limiter. One input transfer per control tick carries the
// throttle, battery voltage and motor current samples; one drive pulse width comes
// back per tick. The multiplies, the divide and the power compare share one
// adder/subtractor, one step per cycle. After its input transfer a tick runs the map,
// then, when the throttle lies strictly inside its bounds, a 10-step multiply and a
// 12-step restoring divide, then the 10-step and 18-step power multiplies, compare
// and ramp; the multiply and divide of the map are skipped when the throttle is
// clamped or the bounds are equal. Input is not ready during a tick;
// the result sits in an output register, so the next tick can start while it waits,
// but that tick holds in its ramp cycle until the previous result is transferred.
// Configuration writes take effect at once and belong to idle time.
module throttle_power_ramp_limiter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tprl_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [tprl_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  tprl_in_if.sink                            in_ch,
  tprl_out_if.source                         out_ch
);
  import tprl_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THROTTLE_LOW:  cfg_q.throttle_low   <= cfg_data_i[ADC_BITS-1:0];
        CFG_THROTTLE_HIGH: cfg_q.throttle_high  <= cfg_data_i[ADC_BITS-1:0];
        CFG_PULSE_LOW:     cfg_q.pulse_low      <= cfg_data_i[PULSE_BITS-1:0];
        CFG_PULSE_HIGH:    cfg_q.pulse_high     <= cfg_data_i[PULSE_BITS-1:0];
        CFG_WATT_LIMIT:    cfg_q.watt_limit     <= cfg_data_i[WATT_BITS-1:0];
        CFG_RAMP_UP_STEP:  cfg_q.ramp_up_step   <= cfg_data_i[STEP_BITS-1:0];
        CFG_RAMP_DOWN:     cfg_q.ramp_down_step <= cfg_data_i[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  tprl_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_ch.valid),
    .in_ready_o    (in_ch.ready),
    .throttle_i    (in_ch.throttle_sample),
    .voltage_i     (in_ch.voltage_sample),
    .current_i     (in_ch.current_sample),
    .out_valid_o   (out_ch.valid),
    .out_ready_i   (out_ch.ready),
    .drive_pulse_o (out_ch.drive_pulse)
  );

endmodule

### src/tprl_checker.sv
module tprl_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [tprl_pkg::PULSE_BITS-1:0] drive_pulse_i
);
  import tprl_pkg::*;

  // busy right after taking a tick
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input still ready after a transfer");

  // idle block stays ready until something arrives
  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_i && !in_valid_i) |=> in_ready_i)
    else $error("ready dropped without an input transfer");

  // a result never appears the cycle after its tick was taken
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !$rose(out_valid_i))
    else $error("result raised too early");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("output valid dropped while stalled");

  a_out_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> $stable(drive_pulse_i))
    else $error("drive pulse changed while stalled");

endmodule

bind throttle_power_ramp_limiter tprl_checker u_tprl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_ch.valid),
  .in_ready_i    (in_ch.ready),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .drive_pulse_i (out_ch.drive_pulse)
);
